FILE: sv/lfupr_pkg.sv
// Shared constants and the frame cell control type for the LFU page replacement block.
package lfupr_pkg;

	localparam int CFG_W          = 5;
	localparam int PAGE_IN_W      = 8;
	localparam int FRAME_OUT_W    = 4;
	localparam int TOTAL_W        = 32;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 8;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	typedef struct packed {
		logic clear_all;
		logic cnt_upd;
		logic load;
	} cell_ctl_t;

endpackage

FILE: sv/lfu_page_replacement_top.sv
// LFU page replacement: frame cell chain, count memory and sequencer.
//
// Input channel (in_valid/in_ready) takes one page reference per beat:
// page_number and last_reference. Output channel (out_valid/out_ready)
// returns one result beat per reference: hit, frame_index, evicted_valid,
// evicted_page and replacement_total.
// frames_in_use is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce this. A
// reference walks the chain of MAX_FRAMES frame cells, one cell per cycle,
// which finds a hit, the first empty frame and the least-count victim. The
// per-page count is read from and written back to the count memory. Before
// the walk, frames_in_use is subtracted from the round-robin pointer until it
// is below frames_in_use, which folds it after frames_in_use shrinks. A new
// reference is taken only after the previous result enters the output register.
// After reset, and after a beat with last_reference set, the count memory is
// swept to zero, one entry per cycle (all 2^PAGE_BITS entries, 256 by default);
// in_ready stays low during the sweep.
// A result waits in the output register while out_ready is low; the next
// reference is still taken and walked, and holds at the end until the
// output register is free.
module lfu_page_replacement_top #(
	parameter int MAX_FRAMES = lfupr_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = lfupr_pkg::PAGE_BITS_DEF,
	parameter int COUNT_BITS = lfupr_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfupr_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lfupr_pkg::PAGE_IN_W-1:0]   page_number,
	input  logic                              last_reference,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [lfupr_pkg::FRAME_OUT_W-1:0] frame_index,
	output logic                              evicted_valid,
	output logic [lfupr_pkg::PAGE_IN_W-1:0]   evicted_page,
	output logic [lfupr_pkg::TOTAL_W-1:0]     replacement_total
);
	import lfupr_pkg::*;

	localparam int FI_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NW   = $clog2(MAX_FRAMES + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NORM,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         frames_q;
	logic [FI_W-1:0]          ptr_q, ptr_eff_q, scan_cnt_q;
	logic [PAGE_BITS-1:0]     page_q, clr_addr_q;
	logic                     last_q;
	logic [TOTAL_W-1:0]       total_q;
	logic                     out_valid_q, hit_q, ev_valid_q;
	logic [FRAME_OUT_W-1:0]   frame_idx_q;
	logic [PAGE_IN_W-1:0]     ev_page_q;
	logic [TOTAL_W-1:0]       out_total_q;

	logic [NW-1:0]            n;
	logic                     fire, replace;
	logic [COUNT_BITS-1:0]    rd_cnt, new_cnt;
	logic [FI_W-1:0]          sel_frame, ptr_next;
	logic [NW-1:0]            frame_inc;
	logic [TOTAL_W-1:0]       total_next;
	logic [MAX_FRAMES-1:0]    load_vec;
	logic                     mem_we;
	logic [PAGE_BITS-1:0]     mem_addr;
	logic [COUNT_BITS-1:0]    mem_wdata;

	logic                     hit_v       [MAX_FRAMES+1];
	logic [FI_W-1:0]          hit_idx_v   [MAX_FRAMES+1];
	logic                     empty_v     [MAX_FRAMES+1];
	logic [FI_W-1:0]          empty_idx_v [MAX_FRAMES+1];
	logic                     best_v      [MAX_FRAMES+1];
	logic [COUNT_BITS-1:0]    best_cnt_v  [MAX_FRAMES+1];
	logic [FI_W-1:0]          best_dist_v [MAX_FRAMES+1];
	logic [FI_W-1:0]          best_idx_v  [MAX_FRAMES+1];
	logic [PAGE_BITS-1:0]     best_page_v [MAX_FRAMES+1];

	always_comb begin
		if (frames_q == '0) begin
			n = NW'(1);
		end else if (32'(frames_q) > MAX_FRAMES) begin
			n = NW'(MAX_FRAMES);
		end else begin
			n = NW'(frames_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	assign hit_v[0]       = 1'b0;
	assign hit_idx_v[0]   = '0;
	assign empty_v[0]     = 1'b0;
	assign empty_idx_v[0] = '0;
	assign best_v[0]      = 1'b0;
	assign best_cnt_v[0]  = '0;
	assign best_dist_v[0] = '0;
	assign best_idx_v[0]  = '0;
	assign best_page_v[0] = '0;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		cell_ctl_t ctl;

		always_comb begin
			ctl.clear_all = fire && last_q;
			ctl.cnt_upd   = fire;
			ctl.load      = load_vec[i];
		end

		lfupr_cell #(
			.PAGE_BITS  (PAGE_BITS),
			.COUNT_BITS (COUNT_BITS),
			.MAX_FRAMES (MAX_FRAMES),
			.IDX        (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.page         (page_q),
			.new_cnt      (new_cnt),
			.n            (n),
			.ptr          (ptr_eff_q),
			.up_hit       (hit_v[i]),
			.up_hit_idx   (hit_idx_v[i]),
			.up_empty     (empty_v[i]),
			.up_empty_idx (empty_idx_v[i]),
			.up_best      (best_v[i]),
			.up_best_cnt  (best_cnt_v[i]),
			.up_best_dist (best_dist_v[i]),
			.up_best_idx  (best_idx_v[i]),
			.up_best_page (best_page_v[i]),
			.dn_hit       (hit_v[i+1]),
			.dn_hit_idx   (hit_idx_v[i+1]),
			.dn_empty     (empty_v[i+1]),
			.dn_empty_idx (empty_idx_v[i+1]),
			.dn_best      (best_v[i+1]),
			.dn_best_cnt  (best_cnt_v[i+1]),
			.dn_best_dist (best_dist_v[i+1]),
			.dn_best_idx  (best_idx_v[i+1]),
			.dn_best_page (best_page_v[i+1])
		);
	end

	lfupr_count_ram #(
		.PAGE_BITS  (PAGE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_count_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_addr),
		.wr_data (mem_wdata),
		.rd_addr (page_q),
		.rd_data (rd_cnt)
	);

	always_comb begin
		fire      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		new_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
		replace   = !hit_v[MAX_FRAMES] && !empty_v[MAX_FRAMES];
		if (hit_v[MAX_FRAMES]) begin
			sel_frame = hit_idx_v[MAX_FRAMES];
		end else if (empty_v[MAX_FRAMES]) begin
			sel_frame = empty_idx_v[MAX_FRAMES];
		end else begin
			sel_frame = best_idx_v[MAX_FRAMES];
		end
		frame_inc  = NW'(sel_frame) + 1'b1;
		ptr_next   = (frame_inc == n) ? '0 : FI_W'(frame_inc);
		total_next = (replace && (total_q != '1)) ? total_q + 1'b1 : total_q;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			load_vec[i] = fire && !hit_v[MAX_FRAMES] && (sel_frame == FI_W'(i));
		end
		mem_we    = (state_q == ST_CLEAR) || fire;
		mem_addr  = (state_q == ST_CLEAR) ? clr_addr_q : page_q;
		mem_wdata = (state_q == ST_CLEAR) ? '0 : new_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			ptr_q       <= '0;
			ptr_eff_q   <= '0;
			scan_cnt_q  <= '0;
			page_q      <= '0;
			last_q      <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			frame_idx_q <= '0;
			ev_valid_q  <= 1'b0;
			ev_page_q   <= '0;
			out_total_q <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						page_q    <= PAGE_BITS'(page_number);
						last_q    <= last_reference;
						ptr_eff_q <= ptr_q;
						state_q   <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (NW'(ptr_eff_q) >= n) begin
						ptr_eff_q <= FI_W'(NW'(ptr_eff_q) - n);
					end else begin
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == FI_W'(MAX_FRAMES - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						hit_q       <= hit_v[MAX_FRAMES];
						frame_idx_q <= FRAME_OUT_W'(sel_frame);
						ev_valid_q  <= replace;
						ev_page_q   <= replace ? PAGE_IN_W'(best_page_v[MAX_FRAMES]) : '0;
						out_total_q <= total_next;
						if (last_q) begin
							ptr_q      <= '0;
							total_q    <= '0;
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else begin
							if (!hit_v[MAX_FRAMES]) begin
								ptr_q <= ptr_next;
							end
							total_q <= total_next;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign in_ready          = (state_q == ST_IDLE);
	assign out_valid         = out_valid_q;
	assign hit               = hit_q;
	assign frame_index       = frame_idx_q;
	assign evicted_valid     = ev_valid_q;
	assign evicted_page      = ev_page_q;
	assign replacement_total = out_total_q;

	a_load_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(load_vec))
		else $error("more than one frame loaded");

	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		fire && replace |-> best_v[MAX_FRAMES])
		else $error("replacement without a victim");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted_valid))
		else $error("hit beat reports an eviction");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_q |=> (state_q == ST_CLEAR) && !in_ready)
		else $error("no clear sweep after last reference");

	a_ptr_folded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> NW'(ptr_eff_q) < n)
		else $error("pointer not folded before scan");

endmodule

FILE: sv/lfupr_count_ram.sv
// Per-page reference count memory, one write port and one registered read port.
module lfupr_count_ram #(
	parameter int PAGE_BITS  = lfupr_pkg::PAGE_BITS_DEF,
	parameter int COUNT_BITS = lfupr_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [PAGE_BITS-1:0]  wr_addr,
	input  logic [COUNT_BITS-1:0] wr_data,
	input  logic [PAGE_BITS-1:0]  rd_addr,
	output logic [COUNT_BITS-1:0] rd_data
);
	import lfupr_pkg::*;

	localparam int DEPTH = 1 << PAGE_BITS;

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/lfupr_cell.sv
// One frame cell: holds a resident page and its count, and passes the lookup beat on.
module lfupr_cell #(
	parameter int PAGE_BITS  = lfupr_pkg::PAGE_BITS_DEF,
	parameter int COUNT_BITS = lfupr_pkg::COUNT_BITS_DEF,
	parameter int MAX_FRAMES = lfupr_pkg::MAX_FRAMES_DEF,
	parameter int IDX        = 0,
	localparam int FI_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int NW        = $clog2(MAX_FRAMES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfupr_pkg::cell_ctl_t    ctl,
	input  logic [PAGE_BITS-1:0]    page,
	input  logic [COUNT_BITS-1:0]   new_cnt,
	input  logic [NW-1:0]           n,
	input  logic [FI_W-1:0]         ptr,
	input  logic                    up_hit,
	input  logic [FI_W-1:0]         up_hit_idx,
	input  logic                    up_empty,
	input  logic [FI_W-1:0]         up_empty_idx,
	input  logic                    up_best,
	input  logic [COUNT_BITS-1:0]   up_best_cnt,
	input  logic [FI_W-1:0]         up_best_dist,
	input  logic [FI_W-1:0]         up_best_idx,
	input  logic [PAGE_BITS-1:0]    up_best_page,
	output logic                    dn_hit,
	output logic [FI_W-1:0]         dn_hit_idx,
	output logic                    dn_empty,
	output logic [FI_W-1:0]         dn_empty_idx,
	output logic                    dn_best,
	output logic [COUNT_BITS-1:0]   dn_best_cnt,
	output logic [FI_W-1:0]         dn_best_dist,
	output logic [FI_W-1:0]         dn_best_idx,
	output logic [PAGE_BITS-1:0]    dn_best_page
);
	import lfupr_pkg::*;

	localparam int DW = NW + 1;
	localparam logic [NW-1:0]   IDX_N = NW'(IDX);
	localparam logic [FI_W-1:0] IDX_F = FI_W'(IDX);

	logic                  valid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic                  hit_q, empty_q, best_q;
	logic [FI_W-1:0]       hit_idx_q, empty_idx_q, best_dist_q, best_idx_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [PAGE_BITS-1:0]  best_page_q;

	logic            active, occupied, match, empty, better;
	logic [DW-1:0]   wrap;
	logic [FI_W-1:0] offs;

	always_comb begin
		active   = IDX_N < n;
		occupied = active && valid_q;
		match    = occupied && (page_q == page);
		empty    = active && !valid_q;
		wrap     = DW'(IDX) + DW'(n) - DW'(ptr);
		offs     = (IDX_F >= ptr) ? (IDX_F - ptr) : FI_W'(wrap);
		better   = occupied && (!up_best || (cnt_q < up_best_cnt) ||
			((cnt_q == up_best_cnt) && (offs < up_best_dist)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear_all) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			page_q <= page;
			cnt_q  <= new_cnt;
		end else if (ctl.cnt_upd && valid_q && (page_q == page)) begin
			cnt_q <= new_cnt;
		end
	end

	// lookup carry, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			best_q  <= 1'b0;
		end else begin
			hit_q   <= up_hit || match;
			empty_q <= up_empty || empty;
			best_q  <= up_best || occupied;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q   <= up_hit ? up_hit_idx : IDX_F;
		empty_idx_q <= up_empty ? up_empty_idx : IDX_F;
		if (better) begin
			best_cnt_q  <= cnt_q;
			best_dist_q <= offs;
			best_idx_q  <= IDX_F;
			best_page_q <= page_q;
		end else begin
			best_cnt_q  <= up_best_cnt;
			best_dist_q <= up_best_dist;
			best_idx_q  <= up_best_idx;
			best_page_q <= up_best_page;
		end
	end

	assign dn_hit       = hit_q;
	assign dn_hit_idx   = hit_idx_q;
	assign dn_empty     = empty_q;
	assign dn_empty_idx = empty_idx_q;
	assign dn_best      = best_q;
	assign dn_best_cnt  = best_cnt_q;
	assign dn_best_dist = best_dist_q;
	assign dn_best_idx  = best_idx_q;
	assign dn_best_page = best_page_q;

endmodule
